@@ src/coset_min_weight_search_assert.svh @@
// ----------------------------------------------------------------------------
// coset_min_weight_search assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef COSET_MIN_WEIGHT_SEARCH_ASSERT_SVH
`define COSET_MIN_WEIGHT_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CMWS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CMWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cmws_pkg.sv @@
// ----------------------------------------------------------------------------
// cmws_pkg
// types and constants shared by the coset minimum weight search blocks
// ----------------------------------------------------------------------------
package cmws_pkg;

	localparam int VECTOR_BITS = 128;
	localparam int HALF_BITS   = 64;
	localparam int WEIGHT_W    = 8;
	localparam int HALF_PC_W   = 7;
	localparam int DIM_W       = 6;
	localparam int ROW_IDX_W   = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// item operation codes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_DIM  = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_REPORT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic write_row;
		logic init;
		logic issue;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic issue_last;
		logic finish;
	} status_t;

endpackage

@@ src/cmws_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmws_ctrl
// sequencer for load and evaluate items of the coset weight search
// ----------------------------------------------------------------------------
module cmws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               operation,
	input  cmws_pkg::status_t  status,
	output cmws_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);

	cmws_pkg::ctrl_state_t state_q;
	cmws_pkg::ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cmws_pkg::ST_IDLE: begin
				if (start && operation == cmws_pkg::OP_EVAL) begin
					state_nxt = cmws_pkg::ST_WALK;
				end
			end
			cmws_pkg::ST_WALK: begin
				if (status.finish) begin
					state_nxt = cmws_pkg::ST_REPORT;
				end else if (status.issue_last) begin
					state_nxt = cmws_pkg::ST_DRAIN;
				end
			end
			cmws_pkg::ST_DRAIN: begin
				if (status.finish) begin
					state_nxt = cmws_pkg::ST_REPORT;
				end
			end
			cmws_pkg::ST_REPORT: begin
				state_nxt = cmws_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = cmws_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy          = (state_q != cmws_pkg::ST_IDLE);
		done          = (state_q == cmws_pkg::ST_REPORT);
		cmd.write_row = (state_q == cmws_pkg::ST_IDLE) && start
			&& (operation == cmws_pkg::OP_LOAD);
		cmd.init      = (state_q == cmws_pkg::ST_IDLE) && start
			&& (operation == cmws_pkg::OP_EVAL);
		// stop issuing as soon as the walk is decided
		cmd.issue     = (state_q == cmws_pkg::ST_WALK) && !status.finish;
	end

endmodule

@@ src/cmws_datapath.sv @@
// ----------------------------------------------------------------------------
// cmws_datapath
// row memory, gray step counter, work vector, popcount, min tracking and threshold check
// ----------------------------------------------------------------------------
module cmws_datapath #(
	parameter int MAX_ROWS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmws_pkg::cmd_t                       cmd,
	output cmws_pkg::status_t                    status,
	input  logic [cmws_pkg::ROW_IDX_W-1:0]       row_index,
	input  logic [cmws_pkg::HALF_BITS-1:0]       word_low,
	input  logic [cmws_pkg::HALF_BITS-1:0]       word_high,
	input  logic                                 cfg_valid,
	input  logic [cmws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmws_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [cmws_pkg::WEIGHT_W-1:0]        min_weight,
	output logic                                 rejected
);

	localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W = MAX_ROWS;

	function automatic logic [cmws_pkg::HALF_PC_W-1:0] pop64(
		input logic [cmws_pkg::HALF_BITS-1:0] x
	);
		logic [1:0] p2  [32];
		logic [2:0] p4  [16];
		logic [3:0] p8  [8];
		logic [4:0] p16 [4];
		logic [5:0] p32 [2];
		for (int i = 0; i < 32; i++) begin
			p2[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			p8[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			p16[i] = {1'b0, p8[2*i]} + {1'b0, p8[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			p32[i] = {1'b0, p16[2*i]} + {1'b0, p16[2*i+1]};
		end
		return {1'b0, p32[0]} + {1'b0, p32[1]};
	endfunction

	// configuration
	logic [cmws_pkg::DIM_W-1:0]    code_dim_q;
	logic [cmws_pkg::WEIGHT_W-1:0] threshold_q;

	// row memory
	logic [cmws_pkg::VECTOR_BITS-1:0] row_mem [MAX_ROWS];

	// step counter
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           mask_q;
	logic [CNT_W-1:0]           mask_nxt;
	logic [CNT_W-1:0]           low_onehot;
	logic [IDX_W-1:0]           low_idx;
	logic [cmws_pkg::DIM_W-1:0] dim_sat;

	// pipeline
	logic                             valid_s1, valid_s2, valid_s3, valid_s4;
	logic                             first_s1, first_s2, first_s3, first_s4;
	logic                             last_s1, last_s2, last_s3, last_s4;
	logic [IDX_W-1:0]                 idx_s1;
	logic [cmws_pkg::VECTOR_BITS-1:0] rdata_s2;
	logic [cmws_pkg::VECTOR_BITS-1:0] work_q;
	logic [cmws_pkg::HALF_PC_W-1:0]   pc_lo_s4, pc_hi_s4;
	logic [cmws_pkg::WEIGHT_W-1:0]    weight;
	logic [cmws_pkg::WEIGHT_W-1:0]    best_q;
	logic                             below_thr;
	logic                             reject_hit;
	logic                             finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_dim_q  <= '0;
			threshold_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cmws_pkg::REG_CODE_DIM:  code_dim_q  <= cfg_data[cmws_pkg::DIM_W-1:0];
				cmws_pkg::REG_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_row && (32'(row_index) < 32'(MAX_ROWS))) begin
			row_mem[IDX_W'(row_index)] <= {word_high, word_low};
		end
	end

	always_comb begin
		dim_sat = (code_dim_q > cmws_pkg::DIM_W'(MAX_ROWS))
			? cmws_pkg::DIM_W'(MAX_ROWS) : code_dim_q;
		for (int i = 0; i < CNT_W; i++) begin
			mask_nxt[i] = (cmws_pkg::DIM_W'(i) < dim_sat);
		end
	end

	// lowest set bit of the step number picks the row
	always_comb begin
		low_onehot = count_q & (~count_q + CNT_W'(1));
		low_idx    = '0;
		for (int i = 0; i < CNT_W; i++) begin
			low_idx = low_idx | (low_onehot[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	assign status.issue_last = &(count_q | ~mask_q);

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			count_q <= '0;
			mask_q  <= mask_nxt;
		end else if (cmd.issue) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (finish) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (count_q == '0);
		last_s1  <= status.issue_last;
		idx_s1   <= low_idx;
		rdata_s2 <= row_mem[idx_s1];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		pc_lo_s4 <= pop64(work_q[cmws_pkg::HALF_BITS-1:0]);
		pc_hi_s4 <= pop64(work_q[cmws_pkg::VECTOR_BITS-1:cmws_pkg::HALF_BITS]);
		first_s4 <= first_s3;
		last_s4  <= last_s3;
	end

	// the leader itself passes through the pipe as step zero, without a row
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			work_q <= {word_high, word_low};
		end else if (valid_s2) begin
			work_q <= work_q ^ (first_s2 ? '0 : rdata_s2);
		end
	end

	always_comb begin
		weight     = {1'b0, pc_lo_s4} + {1'b0, pc_hi_s4};
		below_thr  = (weight < threshold_q);
		reject_hit = valid_s4 && !first_s4 && below_thr;
		finish     = reject_hit || (valid_s4 && last_s4);
	end

	assign status.finish = finish;

	always_ff @(posedge clk) begin
		if (valid_s4 && (first_s4 || weight < best_q)) begin
			best_q <= weight;
		end
		if (finish) begin
			if (reject_hit) begin
				min_weight <= '0;
				rejected   <= 1'b1;
			end else begin
				min_weight <= (first_s4 || weight < best_q) ? weight : best_q;
				rejected   <= 1'b0;
			end
		end
	end

endmodule

@@ src/coset_min_weight_search.sv @@
// ----------------------------------------------------------------------------
// coset_min_weight_search
// minimum weight of the coset f + C over a loaded generator matrix
// ----------------------------------------------------------------------------
// A load item (operation 0) writes one 128-bit generator row and is done in
// the cycle it is accepted; busy stays low and no result follows. An evaluate
// item (operation 1) walks all 2^code_dim codewords in Gray order, one step
// per cycle through the row memory and the popcount pipeline, and reports
// once the last step has passed the popcount and threshold compare; a walk
// that meets a weight under the threshold at a step other than the first
// ends at that step. code_dim above MAX_ROWS counts as MAX_ROWS. The result
// is on min_weight and rejected for exactly one cycle with done high, and
// the receiver has no way to stall it: it must take it in that cycle. Rows
// that the walk reads must have been loaded. Configuration writes are always
// taken (cfg_ready is tied high) and belong to periods where busy is low.
// ----------------------------------------------------------------------------
module coset_min_weight_search #(
	parameter int MAX_ROWS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [cmws_pkg::ROW_IDX_W-1:0]      row_index,
	input  logic [cmws_pkg::HALF_BITS-1:0]      word_low,
	input  logic [cmws_pkg::HALF_BITS-1:0]      word_high,
	// result channel
	output logic                                done,
	output logic [cmws_pkg::WEIGHT_W-1:0]       min_weight,
	output logic                                rejected,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cmws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmws_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cmws_pkg::cmd_t    cmd;
	cmws_pkg::status_t status;

	// registers take a beat in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: idle, walk (issuing steps), drain, report
	cmws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// step counter -> row index -> row read -> xor -> popcount -> min/threshold
	cmws_datapath #(
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.row_index  (row_index),
		.word_low   (word_low),
		.word_high  (word_high),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.min_weight (min_weight),
		.rejected   (rejected)
	);

endmodule

@@ src/cmws_checker.sv @@
// ----------------------------------------------------------------------------
// cmws_checker
// port-level checks of the coset weight search, bound to the top level
// ----------------------------------------------------------------------------
`include "coset_min_weight_search_assert.svh"

module cmws_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                operation,
	input logic                                done,
	input logic [cmws_pkg::WEIGHT_W-1:0]       min_weight,
	input logic                                rejected
);

	// a result beat only ever closes an evaluation in progress
	`CMWS_ASSERT_NOW(a_done_in_busy, done, busy, "result beat outside an evaluation")

	// a rejected search reports zero weight
	`CMWS_ASSERT_NOW(a_reject_zero, done && rejected, min_weight == '0, "rejected with nonzero weight")

	// a weight never exceeds the vector length
	`CMWS_ASSERT_NOW(a_weight_range, done, min_weight <= 8'd128, "weight above vector length")

	// an accepted evaluate item holds the block busy
	`CMWS_ASSERT_NEXT(a_eval_busy, start && !busy && operation == cmws_pkg::OP_EVAL, busy, "evaluate item did not start a walk")

	// a load item finishes in its own cycle
	`CMWS_ASSERT_NEXT(a_load_idle, start && !busy && operation == cmws_pkg::OP_LOAD, !busy && !done, "load item left the block busy")

endmodule

bind coset_min_weight_search cmws_checker u_cmws_checker (.*);
